### rtl/core/xs64_pkg.sv
// Shared types, constants and hash helpers for the xorshift64* generator.
package xs64_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [HALF_W-1:0] half_t;

    localparam word_t DEFAULT_SEED  = 64'h0139_408D_CBBF_7A44;
    localparam word_t XS_MULTIPLIER = 64'h2545_F491_4F6C_DD1D;
    localparam half_t XS_MULT_LO    = XS_MULTIPLIER[HALF_W-1:0];
    localparam half_t XS_MULT_HI    = XS_MULTIPLIER[WORD_W-1:HALF_W];

    // Request operation codes; the fourth code leaves the state alone.
    typedef enum logic [1:0] {
        OP_DRAW   = 2'd0,
        OP_RESEED = 2'd1,
        OP_LOAD   = 2'd2
    } op_t;

    // Seed hash sequencer: four mixing rounds then the zero fix-up.
    typedef enum logic [2:0] {
        HS_IDLE = 3'd0,
        HS_MIX0 = 3'd1,
        HS_MIX1 = 3'd2,
        HS_MIX2 = 3'd3,
        HS_MIX3 = 3'd4,
        HS_FIX  = 3'd5
    } hash_state_t;

    typedef struct packed {
        logic  busy;
        word_t seed_hash;
    } hash_status_t;

    // Request in flight towards the output scrambler.
    typedef struct packed {
        logic  draw;
        word_t state;
    } item_t;

    // One mixing round each; multiplies by 265 and 21 are shift-adds.
    function automatic word_t mix_round0(input word_t k);
        return (~k) + (k << 21);
    endfunction

    function automatic word_t mix_round1(input word_t k);
        word_t t;
        t = k ^ (k >> 24);
        return t + (t << 3) + (t << 8);
    endfunction

    function automatic word_t mix_round2(input word_t k);
        word_t t;
        t = k ^ (k >> 14);
        return t + (t << 2) + (t << 4);
    endfunction

    function automatic word_t mix_round3(input word_t k);
        word_t t;
        t = k ^ (k >> 28);
        return t + (t << 31);
    endfunction

    // Whole hash, used for elaboration-time constants only.
    function automatic word_t mix64(input word_t k);
        return mix_round3(mix_round2(mix_round1(mix_round0(k))));
    endfunction

    function automatic word_t seed_to_state(input word_t s);
        word_t h;
        h = mix64(s);
        return (h == '0) ? mix64(h) : h;
    endfunction

    localparam word_t MIX64_OF_ZERO = mix64(64'd0);
    localparam word_t RESET_STATE   = seed_to_state(DEFAULT_SEED);

endpackage

### rtl/core/xorshift64_star_prng_wang_seeded_core.sv
// Top level of the xorshift64* generator with hashed reseed.
//
//  channel  direction  handshake           payload
//  s_       request in s_valid / s_ready   s_operation, s_state_value
//  m_       result out m_valid / m_ready   m_random_value, m_current_state
//  cfg_     write only cfg_we              cfg_wdata (seed)
//
// One request accepted per clock unless m_ready or a seed hash stalls s_ready;
// its result reaches m_ through the stage register, partial-product register
// and output register. A seed write holds s_ready low in the write cycle and
// while the hash runs (four mixing rounds, zero fix-up). The next-state logic
// (three xorshifts and a mux) feeds the state register directly, closing the
// state loop. Stalls on m_ready back up stage by stage, so bubbles are squeezed
// out before s_ready drops.
// Reset (aresetn, synchronous, active low) loads the default seed's hash.
module xorshift64_star_prng_wang_seeded_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  xs64_pkg::word_t       cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  xs64_pkg::word_t       s_state_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output xs64_pkg::word_t       m_random_value,
    output xs64_pkg::word_t       m_current_state
);
    import xs64_pkg::*;

    hash_status_t hash_status;

    word_t gen_state_reg, gen_state_next;
    logic  stage_valid_reg;
    item_t stage_item_reg, stage_item_next;

    logic  scr_ready;
    logic  stage_en;
    logic  accept;
    word_t shifted;

    xs64_seed_hash u_seed_hash (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (hash_status)
    );

    // Stage register refills when empty or when the scrambler takes its contents.
    assign stage_en = !stage_valid_reg || scr_ready;
    assign s_ready  = stage_en && !hash_status.busy;
    assign accept   = s_valid && s_ready;

    // xorshift update of the current state
    always_comb begin
        shifted = gen_state_reg ^ (gen_state_reg >> 12);
        shifted = shifted ^ (shifted << 25);
        shifted = shifted ^ (shifted >> 27);
    end

    // Next state per request; the unused code keeps the state.
    always_comb begin
        gen_state_next       = gen_state_reg;
        stage_item_next.draw = 1'b0;
        unique case (op_t'(s_operation))
            OP_DRAW: begin
                gen_state_next       = shifted;
                stage_item_next.draw = 1'b1;
            end
            OP_RESEED: begin
                gen_state_next = hash_status.seed_hash;
            end
            OP_LOAD: begin
                gen_state_next = s_state_value;
            end
            default: begin
                gen_state_next = gen_state_reg;
            end
        endcase
        stage_item_next.state = gen_state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_state_reg   <= RESET_STATE;
            stage_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                gen_state_reg <= gen_state_next;
            end
            if (stage_en) begin
                stage_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_item_reg <= stage_item_next;
        end
    end

    xs64_scramble u_scramble (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (stage_valid_reg),
        .in_ready        (scr_ready),
        .in_item         (stage_item_reg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_random_value  (m_random_value),
        .m_current_state (m_current_state)
    );

endmodule

### rtl/core/xs64_seed_hash.sv
// Seed register and multi-cycle hash of the seed into a ready-to-load state.
module xs64_seed_hash (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  xs64_pkg::word_t       cfg_wdata,
    output xs64_pkg::hash_status_t status
);
    import xs64_pkg::*;

    hash_state_t state_reg, state_next;
    word_t       work_reg, work_next;
    word_t       hash_reg, hash_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= HS_IDLE;
            hash_reg  <= RESET_STATE;
        end else begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
    end

    // A write always restarts the hash on the new seed.
    always_comb begin
        state_next = state_reg;
        work_next  = work_reg;
        hash_next  = hash_reg;
        if (cfg_we) begin
            state_next = HS_MIX0;
            work_next  = cfg_wdata;
        end else begin
            unique case (state_reg)
                HS_IDLE: begin
                    state_next = HS_IDLE;
                end
                HS_MIX0: begin
                    work_next  = mix_round0(work_reg);
                    state_next = HS_MIX1;
                end
                HS_MIX1: begin
                    work_next  = mix_round1(work_reg);
                    state_next = HS_MIX2;
                end
                HS_MIX2: begin
                    work_next  = mix_round2(work_reg);
                    state_next = HS_MIX3;
                end
                HS_MIX3: begin
                    work_next  = mix_round3(work_reg);
                    state_next = HS_FIX;
                end
                HS_FIX: begin
                    // zero hash: a second hash of zero is a fixed constant
                    hash_next  = (work_reg == '0) ? MIX64_OF_ZERO : work_reg;
                    state_next = HS_IDLE;
                end
                default: begin
                    state_next = HS_IDLE;
                end
            endcase
        end
    end

    assign status.busy      = (state_reg != HS_IDLE) || cfg_we;
    assign status.seed_hash = hash_reg;

endmodule

### rtl/core/xs64_scramble.sv
// Two-stage 64x64 (low half) multiply of the state by the xorshift64* constant.
module xs64_scramble (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  xs64_pkg::item_t       in_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output xs64_pkg::word_t       m_random_value,
    output xs64_pkg::word_t       m_current_state
);
    import xs64_pkg::*;

    logic  prod_valid_reg;
    logic  prod_draw_reg;
    word_t prod_state_reg;
    word_t prod_lo_reg;
    half_t cross_a_reg;
    half_t cross_b_reg;
    logic  out_valid_reg;
    word_t out_random_reg;
    word_t out_state_reg;

    logic  out_en;
    logic  prod_en;
    half_t cross_sum;
    word_t product;
    half_t cross_a_full;
    half_t cross_b_full;

    assign out_en   = !out_valid_reg || m_ready;
    assign prod_en  = !prod_valid_reg || out_en;
    assign in_ready = prod_en;

    // cross terms only matter modulo 2^32
    assign cross_a_full = in_item.state[WORD_W-1:HALF_W] * XS_MULT_LO;
    assign cross_b_full = in_item.state[HALF_W-1:0] * XS_MULT_HI;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prod_en) begin
                prod_valid_reg <= in_valid;
            end
            if (out_en) begin
                out_valid_reg <= prod_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_en && in_valid) begin
            prod_draw_reg  <= in_item.draw;
            prod_state_reg <= in_item.state;
            prod_lo_reg    <= WORD_W'(in_item.state[HALF_W-1:0]) * WORD_W'(XS_MULT_LO);
            cross_a_reg    <= cross_a_full;
            cross_b_reg    <= cross_b_full;
        end
        if (out_en && prod_valid_reg) begin
            out_random_reg <= prod_draw_reg ? product : '0;
            out_state_reg  <= prod_state_reg;
        end
    end

    assign cross_sum = cross_a_reg + cross_b_reg;
    assign product   = prod_lo_reg + {cross_sum, half_t'(0)};

    assign m_valid         = out_valid_reg;
    assign m_random_value  = out_random_reg;
    assign m_current_state = out_state_reg;

endmodule
